// File: hdl/qof_pkg.sv
// ----------------------------------------------------------------------------
// qof_pkg
// Shared types and constants of the quadratic outline flattener: point kinds,
// sideband bit positions, fixed-point scaling and the step register reset.
// ----------------------------------------------------------------------------
package qof_pkg;

  // Kind of an incoming contour point (tuser bits [1:0] of the slave side)
  typedef enum logic [1:0] {
    MODE_MOVE = 2'd0,
    MODE_LINE = 2'd1,
    MODE_QUAD = 2'd2
  } mode_e;

  // Width of each coordinate field on the stream buses
  localparam int FIELD_W = 32;

  // Fraction bits of the curve parameter, and of the Bernstein weight sum
  localparam int FRAC_BITS  = 16;
  localparam int WSUM_SHIFT = 2 * FRAC_BITS;

  // Slave tuser bit positions
  localparam int IU_MODE_LO = 0;
  localparam int IU_MODE_HI = 1;
  localparam int IU_FIRST   = 2;
  localparam int IU_LAST    = 3;

  // Master tuser bit positions
  localparam int OU_MOVE   = 0;
  localparam int OU_CLOSED = 1;

  // Curve parameter increment after reset, units of 2^-16
  localparam logic [FRAC_BITS-1:0] STEP_RESET = 16'd1966;

endpackage

// File: hdl/quadratic_outline_flattener.sv
// A move or line point, or a close with nothing to draw, is registered straight to the output;
// one is taken per cycle while the output is not held back. A curve point runs the setup phases
// PH_AB to PH_DD for x and then y on the shared multiplier, then S_STEPX and S_STEPY for each
// interior point, a last S_STEPX for the final step check and S_END for the end point; S_STEPY
// and S_END wait while the output is held back, and the next transfer is taken back in S_IDLE.
// Reset: asynchronous, active low; pen and control clear to zero, step to 1966; not ready.
// ----------------------------------------------------------------------------
// quadratic_outline_flattener
// Turns TrueType-style contour points into move-to / line-to points, flattening
// quadratic curves by exact integer forward differencing in signed Q36.32 at the default width.
// ----------------------------------------------------------------------------
module quadratic_outline_flattener import qof_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int MAX_RUN     = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration: curve parameter increment
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [FRAC_BITS-1:0]   cfg_data_i,
  // input points
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [2*FIELD_W-1:0]   s_axis_tdata,   // pt_x [31:0], pt_y [63:32]
  input  logic [3:0]             s_axis_tuser,   // mode [1:0], first_of_spline [2],
                                                 // last_of_spline [3]
  input  logic                   s_axis_tlast,   // closes_contour
  // output path points
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [2*FIELD_W-1:0]   m_axis_tdata,   // out_x [31:0], out_y [63:32]
  output logic [1:0]             m_axis_tuser,   // is_move [0], closed [1]
  output logic                   m_axis_tlast    // last_of_run
);

  localparam int CW  = COORD_WIDTH;
  localparam int NW  = $clog2(MAX_RUN);
  localparam int W   = CW + 36;            // accumulator width
  localparam int AW  = CW + 2;             // second difference of the points
  localparam int BW  = CW + 1;             // first difference of the points
  localparam int MW  = CW + 3;             // multiplier coordinate operand
  localparam int PW  = MW + FRAC_BITS + 1; // multiplier product
  localparam int SAW = CW + 18;            // step times second difference
  localparam logic [NW-1:0] NLIM     = NW'(MAX_RUN - 1);
  localparam logic [W-1:0]  RND_HALF = W'(64'd1 << (WSUM_SHIFT - 1));

  // Setup phases, per coordinate
  localparam logic [2:0] PH_AB  = 3'd0;
  localparam logic [2:0] PH_MB  = 3'd1;
  localparam logic [2:0] PH_MA  = 3'd2;
  localparam logic [2:0] PH_SA  = 3'd3;
  localparam logic [2:0] PH_MLO = 3'd4;
  localparam logic [2:0] PH_MHI = 3'd5;
  localparam logic [2:0] PH_S2A = 3'd6;
  localparam logic [2:0] PH_DD  = 3'd7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_STEPX,
    S_STEPY,
    S_END
  } state_e;

  state_e                state_q;
  logic [FRAC_BITS-1:0]  step_q;
  logic [2:0]            ph_q;
  logic                  crd_q;
  logic [FRAC_BITS:0]    t_q;
  logic [NW-1:0]         n_q;
  logic                  cv_q;
  logic                  lastspl_q;
  logic                  cls_q;

  logic signed [CW-1:0]  pen_q [2];
  logic signed [CW-1:0]  ctl_q [2];
  logic signed [CW-1:0]  end_q [2];
  logic signed [CW-1:0]  npt_q [2];

  logic signed [AW-1:0]  a_q;
  logic signed [BW-1:0]  b_q;
  logic signed [PW-1:0]  prod_q;
  logic [SAW-1:0]        sa_q;
  logic signed [W-1:0]   s2a_q;
  logic signed [W-1:0]   nacc_q  [2];
  logic signed [W-1:0]   dacc_q  [2];
  logic signed [W-1:0]   ddacc_q [2];
  logic signed [CW-1:0]  hx_q;

  logic                  ovalid_q;
  logic                  omove_q;
  logic                  oclosed_q;
  logic                  olast_q;
  logic [FIELD_W-1:0]    ox_q;
  logic [FIELD_W-1:0]    oy_q;

  // Input decode
  logic                  in_acc;
  mode_e                 in_mode;
  logic                  in_first;
  logic                  in_last;
  logic signed [CW-1:0]  in_pt [2];
  logic                  ofree;

  assign in_mode  = mode_e'(s_axis_tuser[IU_MODE_HI:IU_MODE_LO]);
  assign in_first = s_axis_tuser[IU_FIRST];
  assign in_last  = s_axis_tuser[IU_LAST];
  assign in_pt[0] = s_axis_tdata[CW-1:0];
  assign in_pt[1] = s_axis_tdata[FIELD_W+CW-1:FIELD_W];

  // no transfer is taken while reset is held
  assign ofree         = !ovalid_q || m_axis_tready;
  assign s_axis_tready = rst_ni && (state_q == S_IDLE) && ofree;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = rst_ni;

  // Curve end point: the new point itself, or the truncated midpoint
  logic signed [CW:0]    msum [2];
  logic signed [CW-1:0]  ept  [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      msum[i] = (CW+1)'(ctl_q[i]) + (CW+1)'(in_pt[i]);
      if (msum[i][CW]) begin
        msum[i] = msum[i] + (CW+1)'(1);
      end
      ept[i] = in_last ? in_pt[i] : CW'(msum[i] >>> 1);
    end
  end

  // Shared arithmetic: one multiplier for setup, one adder pair for stepping
  logic                  ci;
  logic [FRAC_BITS-1:0]  step_eff;
  logic signed [AW-1:0]  a_d;
  logic signed [BW-1:0]  b_d;
  logic signed [16:0]    mul_a;
  logic signed [MW-1:0]  mul_b;
  logic signed [PW-1:0]  mul_p;
  logic signed [W-1:0]   n_sum;
  logic signed [W-1:0]   d_sum;
  logic [W-1:0]          rnd;
  logic signed [CW-1:0]  rq;

  always_comb begin
    case (state_q)
      S_STEPX: ci = 1'b0;
      S_STEPY: ci = 1'b1;
      default: ci = crd_q;
    endcase
  end

  assign step_eff = (step_q == '0) ? FRAC_BITS'(1) : step_q;
  assign a_d = AW'(pen_q[ci]) - (AW'(ctl_q[ci]) <<< 1) + AW'(end_q[ci]);
  assign b_d = BW'(ctl_q[ci]) - BW'(pen_q[ci]);
  assign mul_a = {1'b0, step_eff};

  always_comb begin
    unique case (ph_q)
      PH_MB:   mul_b = MW'(b_q);
      PH_MA:   mul_b = MW'(a_q);
      PH_MLO:  mul_b = MW'({1'b0, sa_q[FRAC_BITS-1:0]});
      default: mul_b = MW'($signed(sa_q[SAW-1:FRAC_BITS]));
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign n_sum = nacc_q[ci] + dacc_q[ci];
  assign d_sum = dacc_q[ci] + ddacc_q[ci];
  assign rnd   = n_sum + RND_HALF;
  assign rq    = rnd[WSUM_SHIFT+CW-1:WSUM_SHIFT];

  // Sequencer, datapath registers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      step_q    <= STEP_RESET;
      ph_q      <= PH_AB;
      crd_q     <= 1'b0;
      t_q       <= '0;
      n_q       <= '0;
      cv_q      <= 1'b0;
      lastspl_q <= 1'b0;
      cls_q     <= 1'b0;
      a_q       <= '0;
      b_q       <= '0;
      prod_q    <= '0;
      sa_q      <= '0;
      s2a_q     <= '0;
      hx_q      <= '0;
      ovalid_q  <= 1'b0;
      omove_q   <= 1'b0;
      oclosed_q <= 1'b0;
      olast_q   <= 1'b0;
      ox_q      <= '0;
      oy_q      <= '0;
      for (int i = 0; i < 2; i++) begin
        pen_q[i]   <= '0;
        ctl_q[i]   <= '0;
        end_q[i]   <= '0;
        npt_q[i]   <= '0;
        nacc_q[i]  <= '0;
        dacc_q[i]  <= '0;
        ddacc_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        step_q <= cfg_data_i;
      end

      // result taken downstream
      if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            // default: re-emit the pen when the contour closes on no result
            if (s_axis_tlast) begin
              ovalid_q  <= 1'b1;
              omove_q   <= 1'b0;
              oclosed_q <= 1'b1;
              olast_q   <= 1'b1;
              ox_q      <= FIELD_W'(pen_q[0]);
              oy_q      <= FIELD_W'(pen_q[1]);
            end
            unique case (in_mode) inside
              MODE_MOVE, MODE_LINE: begin
                ovalid_q  <= 1'b1;
                omove_q   <= (in_mode == MODE_MOVE);
                oclosed_q <= s_axis_tlast;
                olast_q   <= 1'b1;
                ox_q      <= FIELD_W'(in_pt[0]);
                oy_q      <= FIELD_W'(in_pt[1]);
                pen_q     <= in_pt;
                cv_q      <= 1'b0;
              end
              MODE_QUAD: begin
                if (in_first && in_last) begin
                  cv_q <= 1'b0;
                end else if (in_first || !cv_q) begin
                  ctl_q <= in_pt;
                  cv_q  <= 1'b1;
                end else begin
                  // curve: no result now, the end point carries the close flag
                  ovalid_q  <= 1'b0;
                  end_q     <= ept;
                  npt_q     <= in_pt;
                  lastspl_q <= in_last;
                  cls_q     <= s_axis_tlast;
                  t_q       <= {1'b0, step_eff};
                  n_q       <= '0;
                  crd_q     <= 1'b0;
                  ph_q      <= PH_AB;
                  state_q   <= S_SETUP;
                end
              end
              default: begin
              end
            endcase
          end
        end

        // difference terms: N0 = P0*2^32, D0 = 2^17*s*B + s^2*A, DD = 2*s^2*A
        S_SETUP: begin
          ph_q <= ph_q + 3'd1;
          unique case (ph_q)
            PH_AB: begin
              a_q        <= a_d;
              b_q        <= b_d;
              nacc_q[ci] <= W'(pen_q[ci]) <<< WSUM_SHIFT;
            end
            PH_MB: begin
              prod_q <= mul_p;
            end
            PH_MA: begin
              prod_q     <= mul_p;
              dacc_q[ci] <= W'(prod_q) <<< (FRAC_BITS + 1);
            end
            PH_SA: begin
              sa_q <= prod_q[SAW-1:0];
            end
            PH_MLO: begin
              prod_q <= mul_p;
            end
            PH_MHI: begin
              prod_q <= mul_p;
              s2a_q  <= W'(prod_q);
            end
            PH_S2A: begin
              s2a_q <= s2a_q + (W'(prod_q) <<< FRAC_BITS);
            end
            default: begin
              dacc_q[ci]  <= dacc_q[ci] + s2a_q;
              ddacc_q[ci] <= s2a_q <<< 1;
              if (crd_q) begin
                state_q <= S_STEPX;
              end else begin
                crd_q <= 1'b1;
              end
            end
          endcase
        end

        // interior point while t < 1 and the run has room
        S_STEPX: begin
          if (!t_q[FRAC_BITS] && (n_q != NLIM)) begin
            nacc_q[0] <= n_sum;
            dacc_q[0] <= d_sum;
            hx_q      <= rq;
            state_q   <= S_STEPY;
          end else begin
            state_q <= S_END;
          end
        end

        S_STEPY: begin
          if (ofree) begin
            nacc_q[1] <= n_sum;
            dacc_q[1] <= d_sum;
            ovalid_q  <= 1'b1;
            omove_q   <= 1'b0;
            oclosed_q <= 1'b0;
            olast_q   <= 1'b0;
            ox_q      <= FIELD_W'(hx_q);
            oy_q      <= FIELD_W'(rq);
            t_q       <= t_q + (FRAC_BITS+1)'(step_eff);
            n_q       <= n_q + NW'(1);
            state_q   <= S_STEPX;
          end
        end

        // exact end point closes the run
        S_END: begin
          if (ofree) begin
            ovalid_q  <= 1'b1;
            omove_q   <= 1'b0;
            oclosed_q <= cls_q;
            olast_q   <= 1'b1;
            ox_q      <= FIELD_W'(end_q[0]);
            oy_q      <= FIELD_W'(end_q[1]);
            pen_q     <= end_q;
            if (lastspl_q) begin
              cv_q <= 1'b0;
            end else begin
              ctl_q <= npt_q;
            end
            state_q <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {oy_q, ox_q};
  assign m_axis_tuser  = {oclosed_q, omove_q};
  assign m_axis_tlast  = olast_q;

endmodule
